// ===== rtl/rgb_to_hsv_converter_unit_macros.svh =====
// Assertion macros for the RGB to HSV converter checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_MACROS_SVH

// Same-cycle check, held off while reset is low.
`define RHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pixel converter check failed");

// Next-cycle check that also runs through reset.
`define RHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) ante |=> cons) \
    else $error("pixel converter check failed");

`endif

// ===== rtl/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// No dependencies.
`default_nettype none

package rhc_pkg;

  localparam int CB = 16;          // component width, 8 to 32
  localparam int HW = CB + 3;      // width of the hue divisor, 6 * diff
  localparam int LATENCY = CB + 3; // delay that the checker's $past lookups use

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic          hue_undefined;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;
  } hsv_t;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_unit.sv =====
// RGB to HSV converter: max/min stage, numerator stage, one restoring
// division bit per stage for saturation and hue in parallel. Uses rhc_pkg.
`default_nettype none

// A word taken with start passes through stage A, stage B, the divider stages
// and the output register before its out_valid strobe.
// Throughput: one word per clock; busy is tied low.
// The depth is set by the two bit-serial dividers, one quotient bit a stage.
// Reset (rst_n low, synchronous) clears every stage valid bit and out_valid;
// data registers are not reset.
module rgb_to_hsv_converter_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire rhc_pkg::pixel_t in_pixel,
  output logic               out_valid,
  output rhc_pkg::hsv_t      out_hsv
);

  typedef struct packed {
    logic                   valid;
    logic                   undef;
    logic [rhc_pkg::CB-1:0] mx;
    logic [rhc_pkg::CB-1:0] sat_rem;
    logic [rhc_pkg::CB-1:0] sat_word;  // dividend low bits out, quotient in
    logic [rhc_pkg::HW-1:0] hue_rem;
    logic [rhc_pkg::HW-1:0] hue_den;
    logic [rhc_pkg::CB-1:0] hue_q;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t                   n;
    logic [rhc_pkg::CB:0]   sat_sh;
    logic [rhc_pkg::CB:0]   sat_try;
    logic [rhc_pkg::HW:0]   hue_sh;
    logic [rhc_pkg::HW:0]   hue_try;
    n       = s;
    sat_sh  = {s.sat_rem, s.sat_word[rhc_pkg::CB-1]};
    sat_try = sat_sh - {1'b0, s.mx};
    if (sat_sh >= {1'b0, s.mx}) begin
      n.sat_rem  = sat_try[rhc_pkg::CB-1:0];
      n.sat_word = {s.sat_word[rhc_pkg::CB-2:0], 1'b1};
    end else begin
      n.sat_rem  = sat_sh[rhc_pkg::CB-1:0];
      n.sat_word = {s.sat_word[rhc_pkg::CB-2:0], 1'b0};
    end
    hue_sh  = {s.hue_rem, 1'b0};
    hue_try = hue_sh - {1'b0, s.hue_den};
    if (hue_sh >= {1'b0, s.hue_den}) begin
      n.hue_rem = hue_try[rhc_pkg::HW-1:0];
      n.hue_q   = {s.hue_q[rhc_pkg::CB-2:0], 1'b1};
    end else begin
      n.hue_rem = hue_sh[rhc_pkg::HW-1:0];
      n.hue_q   = {s.hue_q[rhc_pkg::CB-2:0], 1'b0};
    end
    return n;
  endfunction

  // Stage A: max, min, sector
  logic                   a_valid_r;
  logic [rhc_pkg::CB-1:0] a_mx_r, a_mx_nxt;
  logic [rhc_pkg::CB-1:0] a_diff_r, a_diff_nxt;
  logic [rhc_pkg::CB-1:0] a_plus_r, a_plus_nxt;
  logic [rhc_pkg::CB-1:0] a_minus_r, a_minus_nxt;
  rhc_pkg::sector_t       a_sector_r, a_sector_nxt;
  logic [rhc_pkg::CB-1:0] mn;

  always_comb begin
    if (in_pixel.red >= in_pixel.green && in_pixel.red >= in_pixel.blue) begin
      a_sector_nxt = rhc_pkg::SECT_RED;
      a_mx_nxt     = in_pixel.red;
      a_plus_nxt   = in_pixel.green;
      a_minus_nxt  = in_pixel.blue;
    end else if (in_pixel.green >= in_pixel.blue) begin
      a_sector_nxt = rhc_pkg::SECT_GREEN;
      a_mx_nxt     = in_pixel.green;
      a_plus_nxt   = in_pixel.blue;
      a_minus_nxt  = in_pixel.red;
    end else begin
      a_sector_nxt = rhc_pkg::SECT_BLUE;
      a_mx_nxt     = in_pixel.blue;
      a_plus_nxt   = in_pixel.red;
      a_minus_nxt  = in_pixel.green;
    end
    mn = in_pixel.red;
    if (in_pixel.green < mn) mn = in_pixel.green;
    if (in_pixel.blue < mn) mn = in_pixel.blue;
    a_diff_nxt = a_mx_nxt - mn;
  end

  // Stage B: hue numerator and divisor, saturation dividend FULL * diff
  div_t                   b_nxt;
  logic [rhc_pkg::HW-1:0] diff_w;
  logic [rhc_pkg::HW-1:0] base_term;
  logic [rhc_pkg::HW:0]   num_s;

  always_comb begin
    diff_w = {{(rhc_pkg::HW-rhc_pkg::CB){1'b0}}, a_diff_r};
    case (a_sector_r)
      rhc_pkg::SECT_RED:   base_term = '0;
      rhc_pkg::SECT_GREEN: base_term = diff_w << 1;
      rhc_pkg::SECT_BLUE:  base_term = diff_w << 2;
      default:             base_term = '0;
    endcase
    b_nxt.valid   = a_valid_r;
    b_nxt.undef   = (a_diff_r == '0);
    b_nxt.mx      = a_mx_r;
    b_nxt.hue_den = (diff_w << 2) + (diff_w << 1);
    num_s = {1'b0, base_term}
          + {{(rhc_pkg::HW-rhc_pkg::CB+1){1'b0}}, a_plus_r}
          - {{(rhc_pkg::HW-rhc_pkg::CB+1){1'b0}}, a_minus_r};
    // wrap a negative numerator by one full turn
    if (num_s[rhc_pkg::HW]) begin
      b_nxt.hue_rem = num_s[rhc_pkg::HW-1:0] + b_nxt.hue_den;
    end else begin
      b_nxt.hue_rem = num_s[rhc_pkg::HW-1:0];
    end
    b_nxt.hue_q = '0;
    // FULL * diff = (diff << CB) - diff: high half diff-1, low half -diff
    if (b_nxt.undef) begin
      b_nxt.sat_rem = '0;
    end else begin
      b_nxt.sat_rem = a_diff_r - 1'b1;
    end
    b_nxt.sat_word = ~a_diff_r + 1'b1;
  end

  div_t div_r   [0:rhc_pkg::CB];
  div_t div_nxt [0:rhc_pkg::CB];

  // advance one quotient bit a stage; drop every valid bit in reset
  always_comb begin
    div_nxt[0] = b_nxt;
    for (int k = 1; k <= rhc_pkg::CB; k++) begin
      div_nxt[k] = div_step(div_r[k-1]);
    end
    if (!rst_n) begin
      for (int k = 0; k <= rhc_pkg::CB; k++) begin
        div_nxt[k].valid = 1'b0;
      end
    end
  end

  logic          out_valid_r;
  rhc_pkg::hsv_t out_hsv_r, out_hsv_nxt;

  always_comb begin
    out_hsv_nxt.hue_undefined = div_r[rhc_pkg::CB].undef;
    out_hsv_nxt.brightness    = div_r[rhc_pkg::CB].mx;
    if (div_r[rhc_pkg::CB].undef) begin
      out_hsv_nxt.hue        = '0;
      out_hsv_nxt.saturation = '0;
    end else begin
      out_hsv_nxt.hue        = div_r[rhc_pkg::CB].hue_q;
      out_hsv_nxt.saturation = div_r[rhc_pkg::CB].sat_word;
    end
  end

  always_ff @(posedge clk) begin
    a_mx_r     <= a_mx_nxt;
    a_diff_r   <= a_diff_nxt;
    a_plus_r   <= a_plus_nxt;
    a_minus_r  <= a_minus_nxt;
    a_sector_r <= a_sector_nxt;
    div_r      <= div_nxt;
    out_hsv_r  <= out_hsv_nxt;
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= start;
      out_valid_r <= div_r[rhc_pkg::CB].valid;
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_hsv   = out_hsv_r;

endmodule

`default_nettype wire

// ===== rtl/rhc_checker.sv =====
// Port-level checks for rgb_to_hsv_converter_unit, bound to the top level.
// Uses rhc_pkg and rgb_to_hsv_converter_unit_macros.svh.
`default_nettype none
`include "rgb_to_hsv_converter_unit_macros.svh"

module rhc_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire rhc_pkg::pixel_t in_pixel,
  input wire logic            out_valid,
  input wire rhc_pkg::hsv_t   out_hsv
);

  function automatic logic [rhc_pkg::CB-1:0] max3(rhc_pkg::pixel_t p);
    logic [rhc_pkg::CB-1:0] m;
    m = p.red;
    if (p.green > m) m = p.green;
    if (p.blue > m) m = p.blue;
    return m;
  endfunction

  // grey pixel: hue and saturation forced to zero; otherwise saturation nonzero
  property p_undef_zero;
    out_valid |-> (out_hsv.hue_undefined == (out_hsv.saturation == '0)) &&
                  (!out_hsv.hue_undefined || out_hsv.hue == '0);
  endproperty

  // brightness is the largest component of the input word at $past depth rhc_pkg::LATENCY
  property p_brightness_max;
    out_valid |-> out_hsv.brightness == max3($past(in_pixel, rhc_pkg::LATENCY));
  endproperty

  // a result strobe only where start was high at $past depth rhc_pkg::LATENCY
  `RHC_ASSERT(a_out_has_source, out_valid |-> $past(start, rhc_pkg::LATENCY))
  `RHC_ASSERT(a_undef_zero, p_undef_zero)
  `RHC_ASSERT(a_brightness_max, p_brightness_max)
  // one word a clock: the block never holds the sender off
  `RHC_ASSERT(a_never_busy, !busy)
  // reset drops any strobe on the next edge
  `RHC_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid)

endmodule

bind rgb_to_hsv_converter_unit rhc_checker u_rhc_checker (.*);

`default_nettype wire
